[src/ewtk_pkg.sv]
package ewtk_pkg;

   localparam int STAMP_W = 32;
   localparam int EST_W = 44;
   localparam int COV_W = 24;
   localparam int DIST_W = 26;
   localparam int K_W = 17;
   localparam int NOISE_W = 22;
   localparam int SKIP_W = 4;
   localparam int FRAC_W = 16;
   localparam int PP_W = 25;
   localparam int DEN_W = 26;
   localparam int HALF_W = 22;

   // floor(x / 100) == (x * MAGIC) >> 37 for every 32-bit x
   localparam logic [31:0] PRESCALE_MAGIC = 32'h51EB_851F;
   localparam int PRESCALE_SHIFT = 37;
   localparam logic [K_W-1:0] ONE_Q16 = K_W'(65536);
   localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
   localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // floor(x / 125) == (x * DIV125_MAGIC) >> 33 for every 27-bit x
   localparam int QDIV_W = 27;
   localparam logic [QDIV_W-1:0] DIV125_MAGIC = QDIV_W'(68719477);
   localparam int DIV125_SHIFT = 33;
   localparam logic [QDIV_W-1:0] DIV125 = QDIV_W'(125);
   localparam int ZLO_W = 20;
   // 65536 / 1000 == 8192 / 125
   localparam int MEAS_SHIFT = 13;
   localparam int Z_LAT = 4;

   localparam logic [1:0] REG_SKIP = 2'd0;
   localparam logic [1:0] REG_QNOISE = 2'd1;
   localparam logic [1:0] REG_RNOISE = 2'd2;

   typedef struct packed {
      logic [SKIP_W-1:0] skip_events;
      logic [NOISE_W-1:0] process_noise;
      logic [NOISE_W-1:0] measure_noise;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic skip_inc;
      logic rise;
      logic push;
      logic copy;
      logic rank_step;
      logic z_start;
      logic k_start;
      logic div_step;
      logic mul;
      logic update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic expect_rising;
      logic rank_done;
      logic z_done;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

[src/echo_width_trimmed_kalman_unit.sv]
// A skipped or rising-edge word returns the unit to idle without a result. A falling edge
//   raises rsp_tvalid after acceptance, once the rank pass over the window and the 41-step
//   gain division are through; a held result adds its stall.
// Throughput: one word at a time; the next word is taken once the previous is done.
// Reset (synchronous): window, edge state and filter state cleared, registers to defaults.
module echo_width_trimmed_kalman_unit #(
   parameter int WINDOW_DEPTH = 50,
   parameter int TRIM_LOW = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] edge_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [25:0] distance_value, [57:26] pulse_width
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ewtk_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type status;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skip_events <= SKIP_W'(5);
         cfg_ff.process_noise <= NOISE_W'(6554);
         cfg_ff.measure_noise <= NOISE_W'(19661);
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_SKIP: cfg_ff.skip_events <= csr_pwdata[SKIP_W-1:0];
            REG_QNOISE: cfg_ff.process_noise <= csr_pwdata[NOISE_W-1:0];
            REG_RNOISE: cfg_ff.measure_noise <= csr_pwdata[NOISE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SKIP: csr_prdata = 32'(cfg_ff.skip_events);
         REG_QNOISE: csr_prdata = 32'(cfg_ff.process_noise);
         REG_RNOISE: csr_prdata = 32'(cfg_ff.measure_noise);
         default: csr_prdata = '0;
      endcase
   end

   ewtk_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   ewtk_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .TRIM_LOW(TRIM_LOW)) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .cfg(cfg_ff),
      .edge_time(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted while busy");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a word in progress");

   a_no_load_in_skip: assert property (@(posedge clock) disable iff (reset)
      cmd.skip_inc |=> !rsp_tvalid || $past(rsp_tvalid))
      else $error("skipped word produced a result");

endmodule

[src/ewtk_div.sv]
module ewtk_div #(
   parameter int DIV_N = 54,
   parameter int DEN_W = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic [DIV_N-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [DIV_N-1:0] quotient,
   output logic             last
);
   localparam int CNT_W = $clog2(DIV_N);

   logic [DIV_N-1:0] dq_ff, dq_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0] rem_sh, rem_sub;
   logic ge;

   always_comb begin
      rem_sh = {rem_ff, dq_ff[DIV_N-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge = rem_sh >= {1'b0, den_ff};
      dq_in = dq_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dq_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         dq_in = {dq_ff[DIV_N-2:0], ge};
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = dq_ff;
   assign last = cnt_ff == CNT_W'(DIV_N - 1);

endmodule

[src/ewtk_datapath.sv]
module ewtk_datapath #(
   parameter int WINDOW_DEPTH = 50,
   parameter int TRIM_LOW = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  ewtk_pkg::cmd_type   cmd,
   output ewtk_pkg::status_type status,
   input  ewtk_pkg::cfg_type   cfg,
   input  logic [31:0]         edge_time,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata
);
   import ewtk_pkg::*;

   localparam int D = WINDOW_DEPTH;
   localparam int RC_W = $clog2(D + 2);
   localparam int RK_W = $clog2(D + 1);
   localparam int SUM_W = STAMP_W + $clog2(D + 1);
   localparam int KDIV_N = PP_W + FRAC_W;
   localparam int PROD_W = HALF_W + K_W;
   localparam int MAG_W = PROD_W + HALF_W + 1;
   localparam int PN_W = K_W + PP_W;
   localparam int QPROD_W = 2 * QDIV_W;
   localparam int ZR_W = QDIV_W - ZLO_W;
   localparam int ZS_W = SUM_W + MEAS_SHIFT;

   logic [31:0] edge_ff;
   logic [63:0] scale_ff;
   logic [STAMP_W-1:0] stamp, width;
   logic [SKIP_W-1:0] event_cnt_ff;
   logic expect_rising_ff;
   logic [STAMP_W-1:0] start_ff, width_ff;
   logic [STAMP_W-1:0] window_ff [D];
   logic [STAMP_W-1:0] rot_ff [D];
   logic [RC_W-1:0] rank_cnt_ff;
   logic [D-1:0] cmp_ff, cmp_in;
   logic [STAMP_W-1:0] cand_a_ff, cand_b_ff;
   logic va_ff, vb_ff;
   logic [RK_W-1:0] rank_ff, rank_in;
   logic [SUM_W-1:0] sum_ff;
   logic [QDIV_W-1:0] zqh_ff, zmid_ff, zql_ff, zf_ff;
   logic [QDIV_W-1:0] zhi, zrh, zb;
   logic [ZR_W-1:0] zb_ff;
   logic [Z_LAT-1:0] zpipe_ff;
   logic [ZS_W-1:0] z_full;
   logic [EST_W-1:0] z_ff, z_in;
   logic [PP_W-1:0] pp_ff, pp_in;
   logic [DEN_W-1:0] den_in;
   logic den_zero_ff;
   logic [KDIV_N-1:0] div_dividend, quotient;
   logic div_last;
   logic [K_W-1:0] k;
   logic [EST_W-1:0] diff;
   logic neg_ff;
   logic [PROD_W-1:0] prod_lo_ff, prod_hi_ff;
   logic [PN_W-1:0] pn_ff;
   logic [MAG_W-1:0] mag_full;
   logic [EST_W-1:0] est_ff, cov_unused;
   logic [COV_W-1:0] cov_ff, cov_in;
   logic [EST_W-1:0] est_in;
   logic [DIST_W-1:0] dist_sat;
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   function automatic logic [QDIV_W-1:0] div125(input logic [QDIV_W-1:0] x);
      logic [QPROD_W-1:0] prod;
      prod = QPROD_W'(x) * QPROD_W'(DIV125_MAGIC);
      return QDIV_W'(prod[QPROD_W-1:DIV125_SHIFT]);
   endfunction

   assign stamp = STAMP_W'(scale_ff[63:PRESCALE_SHIFT]);
   assign width = stamp - start_ff;
   assign cov_unused = '0;

   always_comb begin
      for (int j = 0; j < D; j++) begin
         cmp_in[j] = (window_ff[j] < rot_ff[0])
            || ((window_ff[j] == rot_ff[0]) && (RC_W'(j) < rank_cnt_ff));
      end
      rank_in = '0;
      for (int j = 0; j < D; j++) begin
         rank_in = rank_in + RK_W'(cmp_ff[j]);
      end
   end

   // sum = 125 * (qh * 2^20 + ql) + b, z = (qh * 2^20 + ql) * 8192 + floor(b * 8192 / 125)
   assign zhi = QDIV_W'(sum_ff[SUM_W-1:ZLO_W]);
   assign zrh = zhi - zqh_ff * DIV125;
   assign zb = zmid_ff - zql_ff * DIV125;
   assign z_full = (ZS_W'(zqh_ff) << (ZLO_W + MEAS_SHIFT)) + (ZS_W'(zql_ff) << MEAS_SHIFT)
      + ZS_W'(zf_ff);
   assign z_in = (|z_full[ZS_W-1:EST_W]) ? EST_MAX : z_full[EST_W-1:0];

   assign pp_in = PP_W'(cov_ff) + PP_W'(cfg.process_noise);
   assign den_in = DEN_W'(pp_in) + DEN_W'(cfg.measure_noise);
   assign div_dividend = {pp_in, {FRAC_W{1'b0}}};

   ewtk_div #(.DIV_N(KDIV_N), .DEN_W(DEN_W)) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.k_start),
      .step(cmd.div_step),
      .dividend(div_dividend),
      .divisor(den_in),
      .quotient(quotient),
      .last(div_last)
   );

   assign k = den_zero_ff ? '0 : quotient[K_W-1:0];
   assign diff = (z_ff >= est_ff) ? z_ff - est_ff : est_ff - z_ff;
   assign mag_full = {prod_hi_ff, {HALF_W{1'b0}}} + MAG_W'(prod_lo_ff);

   always_comb begin
      if (neg_ff) begin
         est_in = est_ff - mag_full[FRAC_W +: EST_W];
      end else begin
         est_in = est_ff + mag_full[FRAC_W +: EST_W];
      end
      if (|pn_ff[PN_W-1:FRAC_W+COV_W]) begin
         cov_in = COV_MAX;
      end else begin
         cov_in = pn_ff[FRAC_W +: COV_W];
      end
      if (|est_ff[EST_W-1:FRAC_W+DIST_W]) begin
         dist_sat = DIST_MAX;
      end else begin
         dist_sat = est_ff[FRAC_W +: DIST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_cnt_ff <= '0;
         expect_rising_ff <= 1'b0;
         start_ff <= '0;
         est_ff <= '0;
         cov_ff <= '0;
         rank_cnt_ff <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         zpipe_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < D; j++) begin
            window_ff[j] <= '0;
         end
      end else begin
         if (cmd.skip_inc) begin
            event_cnt_ff <= event_cnt_ff + SKIP_W'(1);
         end
         if (cmd.rise) begin
            start_ff <= stamp;
            expect_rising_ff <= 1'b0;
         end
         if (cmd.push) begin
            expect_rising_ff <= 1'b1;
            event_cnt_ff <= '0;
            window_ff[0] <= width;
            for (int j = 1; j < D; j++) begin
               window_ff[j] <= window_ff[j-1];
            end
         end
         if (cmd.copy) begin
            rank_cnt_ff <= '0;
            va_ff <= 1'b0;
            vb_ff <= 1'b0;
         end else if (cmd.rank_step) begin
            rank_cnt_ff <= rank_cnt_ff + RC_W'(1);
            va_ff <= rank_cnt_ff < RC_W'(D);
            vb_ff <= va_ff;
         end
         if (cmd.z_start) begin
            zpipe_ff <= Z_LAT'(1);
         end else begin
            zpipe_ff <= zpipe_ff << 1;
         end
         if (cmd.update) begin
            est_ff <= est_in | cov_unused;
            cov_ff <= cov_in;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         edge_ff <= edge_time;
      end
      if (cmd.scale) begin
         scale_ff <= 64'(edge_ff) * 64'(PRESCALE_MAGIC);
      end
      if (cmd.push) begin
         width_ff <= width;
      end
      if (cmd.copy) begin
         rot_ff <= window_ff;
         sum_ff <= '0;
      end else if (cmd.rank_step) begin
         for (int j = 0; j < D - 1; j++) begin
            rot_ff[j] <= rot_ff[j+1];
         end
         rot_ff[D-1] <= rot_ff[0];
         cmp_ff <= cmp_in;
         cand_a_ff <= rot_ff[0];
         rank_ff <= rank_in;
         cand_b_ff <= cand_a_ff;
         if (vb_ff && (int'(rank_ff) >= TRIM_LOW) && (int'(rank_ff) < D - TRIM_LOW)) begin
            sum_ff <= sum_ff + SUM_W'(cand_b_ff);
         end
      end
      zqh_ff <= div125(zhi);
      zmid_ff <= {zrh[ZR_W-1:0], sum_ff[ZLO_W-1:0]};
      zql_ff <= div125(zmid_ff);
      zb_ff <= zb[ZR_W-1:0];
      zf_ff <= div125(QDIV_W'({zb_ff, {MEAS_SHIFT{1'b0}}}));
      if (cmd.k_start) begin
         z_ff <= z_in;
         pp_ff <= pp_in;
         den_zero_ff <= den_in == '0;
      end
      if (cmd.mul) begin
         neg_ff <= z_ff < est_ff;
         prod_lo_ff <= PROD_W'(diff[HALF_W-1:0]) * PROD_W'(k);
         prod_hi_ff <= PROD_W'(diff[EST_W-1:HALF_W]) * PROD_W'(k);
         pn_ff <= PN_W'(ONE_Q16 - k) * PN_W'(pp_ff);
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {6'b0, width_ff, dist_sat};
      end
   end

   assign status.skip = event_cnt_ff < cfg.skip_events;
   assign status.expect_rising = expect_rising_ff;
   assign status.rank_done = rank_cnt_ff == RC_W'(D + 1);
   assign status.z_done = zpipe_ff[Z_LAT-1];
   assign status.div_last = div_last;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

[src/ewtk_ctrl.sv]
module ewtk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ewtk_pkg::status_type status,
   output ewtk_pkg::cmd_type    cmd
);
   import ewtk_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_SCALE  = 12'b0000_0000_0010,
      ST_DECIDE = 12'b0000_0000_0100,
      ST_COPY   = 12'b0000_0000_1000,
      ST_RANK   = 12'b0000_0001_0000,
      ST_ZSTART = 12'b0000_0010_0000,
      ST_ZWAIT  = 12'b0000_0100_0000,
      ST_KSTART = 12'b0000_1000_0000,
      ST_KWAIT  = 12'b0001_0000_0000,
      ST_MUL    = 12'b0010_0000_0000,
      ST_UPDATE = 12'b0100_0000_0000,
      ST_OUT    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (status.skip) begin
               cmd.skip_inc = 1'b1;
               state_in = ST_IDLE;
            end else if (status.expect_rising) begin
               cmd.rise = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            state_in = ST_RANK;
         end
         ST_RANK: begin
            cmd.rank_step = 1'b1;
            if (status.rank_done) state_in = ST_ZSTART;
         end
         ST_ZSTART: begin
            cmd.z_start = 1'b1;
            state_in = ST_ZWAIT;
         end
         ST_ZWAIT: begin
            if (status.z_done) state_in = ST_KSTART;
         end
         ST_KSTART: begin
            cmd.k_start = 1'b1;
            state_in = ST_KWAIT;
         end
         ST_KWAIT: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

[test/tb_echo_width_trimmed_kalman_unit.sv]
`timescale 1ns / 1ps
module tb_echo_width_trimmed_kalman_unit;
   import ewtk_pkg::*;

   localparam int DEPTH = 50;
   localparam int TRIM = 20;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   echo_width_trimmed_kalman_unit dut (.*);

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [31:0]       width;
   } echo_result_type;

   echo_result_type pending_results[$];
   int errors = 0;
   longint cycles = 0;
   bit quiet_sink = 1'b0;
   bit quiet_source = 1'b0;

   // predictor state
   logic [3:0]  skip_cfg;
   logic [21:0] q_cfg;
   logic [21:0] r_cfg;
   logic [31:0] win [DEPTH];
   bit          want_rise;
   logic [3:0]  ev_count;
   logic [31:0] start_t;
   logic [43:0] est;
   logic [23:0] cov;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[echo_width_trimmed_kalman_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] trimmed_window_sum();
      logic [31:0] s [DEPTH];
      logic [31:0] v;
      logic [63:0] acc;
      int j;
      acc = 0;
      for (int i = 0; i < DEPTH; i++) s[i] = win[i];
      for (int i = 1; i < DEPTH; i++) begin
         v = s[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      for (int i = TRIM; i < DEPTH - TRIM; i++) acc += s[i];
      return acc;
   endfunction

   task automatic predict_edge(input logic [31:0] raw);
      logic [31:0] stamp, w;
      logic [127:0] z, pp, den, k, mag, pn, e;
      echo_result_type r;
      stamp = raw / 32'd100;
      if (ev_count < skip_cfg) begin
         ev_count = ev_count + 4'd1;
         return;
      end
      if (want_rise) begin
         start_t = stamp;
         want_rise = 0;
         return;
      end
      want_rise = 1;
      w = stamp - start_t;
      for (int i = DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = w;
      z = (128'(trimmed_window_sum()) << 16) / 1000;
      if (z > 128'(EST_MAX)) z = 128'(EST_MAX);
      pp = 128'(cov) + 128'(q_cfg);
      den = pp + 128'(r_cfg);
      k = (den != 0) ? (pp << 16) / den : 0;
      e = 128'(est);
      if (z >= e) begin
         mag = ((z - e) * k) >> 16;
         e = e + mag;
      end else begin
         mag = ((e - z) * k) >> 16;
         e = e - mag;
      end
      if (e > 128'(EST_MAX)) e = 128'(EST_MAX);
      est = e[43:0];
      pn = ((128'd65536 - k) * pp) >> 16;
      cov = (pn > 128'(COV_MAX)) ? COV_MAX : pn[23:0];
      ev_count = 0;
      r.distance = (est >> 16) > 44'(DIST_MAX) ? DIST_MAX : est[41:16];
      r.width = w;
      pending_results.push_back(r);
   endtask

   // result checker and sink stalls
   always @(posedge clock) begin
      echo_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected word %h", $time, rsp_tdata);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[25:0] !== exp_r.distance) begin
               errors++;
               $display("%0t distance exp %0d got %0d", $time, exp_r.distance,
                        rsp_tdata[25:0]);
            end
            if (rsp_tdata[57:26] !== exp_r.width) begin
               errors++;
               $display("%0t width exp %0d got %0d", $time, exp_r.width,
                        rsp_tdata[57:26]);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 10);
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_SKIP:   skip_cfg = val[3:0];
         REG_QNOISE: q_cfg = val[21:0];
         REG_RNOISE: r_cfg = val[21:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_edge(input logic [31:0] raw);
      @(negedge clock);
      while (!quiet_source && $urandom_range(99) < 10) @(negedge clock);
      req_tvalid <= 1; req_tdata <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_edge(raw);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // one measurement: skip events, rising, falling
   task automatic send_pulse(input logic [31:0] t0, input logic [31:0] len);
      for (int i = 0; i < skip_cfg; i++) send_edge($urandom);
      send_edge(t0);
      send_edge(t0 + len);
   endtask

   task automatic test_directed();
      send_edge(32'h0);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'd99);
      send_edge(32'd100);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0);
      drain();
      csr_write(REG_SKIP, 0);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0);
      send_edge(32'h0);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'hAAAA_AAAA);
      send_edge(32'h5555_5555);
      drain();
   endtask

   task automatic test_noise_extremes();
      csr_write(REG_QNOISE, 0);
      csr_write(REG_RNOISE, 1);
      send_pulse(32'd1000, 32'd50000);
      drain();
      csr_write(REG_QNOISE, 32'h3F_FFFF);
      csr_write(REG_RNOISE, 32'h3F_FFFF);
      for (int i = 0; i < 6; i++) send_pulse($urandom, 32'hFFFF_FFFF);
      drain();
      csr_write(REG_SKIP, 15);
      send_pulse($urandom, $urandom_range(100000));
      drain();
   endtask

   task automatic test_random(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 85) begin
            send_pulse($urandom, $urandom_range(3) == 0 ? $urandom
                                                        : $urandom_range(2_000_000));
            sent += skip_cfg + 2;
         end else begin
            send_edge($urandom);
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      skip_cfg = 4'd5; q_cfg = 22'd6554; r_cfg = 22'd19661;
      for (int i = 0; i < DEPTH; i++) win[i] = 0;
      want_rise = 0; ev_count = 0; start_t = 0; est = 0; cov = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_noise_extremes();
      csr_write(REG_SKIP, 0);
      csr_write(REG_QNOISE, 6554);
      csr_write(REG_RNOISE, 19661);
      test_random(300);
      csr_write(REG_SKIP, 2);
      csr_write(REG_QNOISE, $urandom_range(32'h3F_FFFF));
      csr_write(REG_RNOISE, $urandom_range(1, 32'h3F_FFFF));
      quiet_source = 1; quiet_sink = 1;
      test_random(200);
      quiet_source = 0; quiet_sink = 0;
      csr_write(REG_SKIP, 1);
      test_random(300);
      if (errors == 0 && pending_results.size() == 0)
         $display("[echo_width_trimmed_kalman_unit] OK");
      else
         $display("[echo_width_trimmed_kalman_unit] ERROR");
      $finish;
   end
endmodule
